// ===== rtl/sugeno_fuzzy_controller_defines.svh =====
// Assertion macros used by the fuzzy controller checker
`ifndef SUGENO_FUZZY_CONTROLLER_DEFINES_SVH
`define SUGENO_FUZZY_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfc_pkg.sv =====
// Shared constants, types and divider step functions of the fuzzy controller
package sfc_pkg;

  localparam int SampleW       = 16;
  localparam int NumSets       = 3;
  localparam int NumMu         = 2 * NumSets;
  localparam int NumRules      = NumSets * NumSets;
  localparam int NumPeaks      = 6;
  localparam int CfgIdxW       = 3;
  localparam int MuFrac        = 16;
  localparam int MuW           = MuFrac + 1;
  localparam int DiffW         = SampleW + 1;
  localparam int YW            = SampleW + 3;
  localparam int ProdW         = MuW + 1 + YW;
  localparam int NumW          = ProdW + 4;
  localparam int DenW          = MuW + 3;
  localparam int RemW          = (DiffW > DenW) ? DiffW : DenW;
  localparam int QW            = SampleW + 2;
  localparam int OutW          = 24;
  localparam int StepsPerStage = 2;
  localparam int MuStages      = MuFrac / StepsPerStage;
  localparam int OutStages     = (QW + StepsPerStage - 1) / StepsPerStage;
  localparam int OutBits       = OutStages * StepsPerStage;
  localparam int SatW          = (OutBits + 2 > OutW) ? OutBits + 2 : OutW;
  localparam int InW           = ((2 * SampleW + 7) / 8) * 8;

  localparam logic signed [SatW-1:0] SatMax = SatW'((64'sd1 <<< (OutW - 1)) - 64'sd1);
  localparam logic signed [SatW-1:0] SatMin = -SatMax - SatW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ERR_LOW  = 3'd0,
    CFG_ERR_MID  = 3'd1,
    CFG_ERR_HIGH = 3'd2,
    CFG_CHG_LOW  = 3'd3,
    CFG_CHG_MID  = 3'd4,
    CFG_CHG_HIGH = 3'd5
  } cfg_idx_e;

  localparam logic [SampleW-1:0] PeakReset [NumPeaks] = '{
    SampleW'(1280), SampleW'(2560), SampleW'(3840),
    SampleW'(256),  SampleW'(512),  SampleW'(768)
  };

  typedef enum logic [1:0] {
    MU_ZERO = 2'd0,
    MU_ONE  = 2'd1,
    MU_DIV  = 2'd2
  } mu_kind_e;

  typedef struct packed {
    logic            q;
    logic [RemW-1:0] r;
  } dstep_t;

  typedef struct packed {
    mu_kind_e          kind;
    logic [RemW-1:0]   rem;
    logic [RemW-1:0]   den;
    logic [MuFrac-1:0] q;
  } mu_div_t;

  typedef struct packed {
    logic               fired;
    logic               neg;
    logic [RemW-1:0]    rem;
    logic [RemW-1:0]    den;
    logic [OutBits-1:0] lo;
    logic [OutBits-1:0] q;
  } out_div_t;

  function automatic dstep_t div_step(input logic [RemW-1:0] rem,
                                      input logic [RemW-1:0] den,
                                      input logic            b);
    logic [RemW:0] t;
    dstep_t        o;
    t   = {rem, b};
    o.q = (t >= {1'b0, den});
    o.r = o.q ? RemW'(t - {1'b0, den}) : t[RemW-1:0];
    return o;
  endfunction

  function automatic mu_div_t mu_adv(input mu_div_t x);
    mu_div_t y;
    dstep_t  s;
    y = x;
    for (int k = 0; k < StepsPerStage; k++) begin
      s     = div_step(y.rem, y.den, 1'b0);
      y.rem = s.r;
      y.q   = {y.q[MuFrac-2:0], s.q};
    end
    return y;
  endfunction

  function automatic out_div_t out_adv(input out_div_t x);
    out_div_t y;
    dstep_t   s;
    y = x;
    for (int k = 0; k < StepsPerStage; k++) begin
      s     = div_step(y.rem, y.den, y.lo[OutBits-1]);
      y.rem = s.r;
      y.lo  = {y.lo[OutBits-2:0], 1'b0};
      y.q   = {y.q[OutBits-2:0], s.q};
    end
    return y;
  endfunction

endpackage

// ===== rtl/sugeno_fuzzy_controller.sv =====
// Top level: pipelined first-order Takagi-Sugeno fuzzy controller
// Throughput: one beat per cycle unless the output stalls; sixteen
// membership and eighteen output quotient bits are resolved two per stage
// in pipelined dividers.
// A stalled output holds the whole pipeline in place.
// Reset clears all valid bits and loads the default set peaks.
module sugeno_fuzzy_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfc_pkg::SampleW-1:0]   cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [sfc_pkg::InW-1:0]       s_axis_tdata_i,  // error_in, change_in
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [sfc_pkg::OutW-1:0]      m_axis_tdata_o,  // control_out
  output logic                          m_axis_tuser_o   // no_rule_fired
);
  import sfc_pkg::*;

  logic                      en;
  logic signed [SampleW-1:0] peak_q [NumPeaks];

  logic                      s_e, s_c;
  logic signed [SampleW-1:0] in_e, in_c;

  mu_div_t                   md_q [MuStages+1][NumMu];
  logic [MuStages:0]         mv_q;
  logic signed [SampleW-1:0] me_q [MuStages+1];
  logic signed [SampleW-1:0] mc_q [MuStages+1];

  logic [MuW-1:0]            mu    [NumMu];
  logic [2*MuW-1:0]          wprod [NumRules];
  logic [MuW-1:0]            w_d   [NumRules];
  logic [MuW-1:0]            w_q   [NumRules];
  logic [YW-1:0]             y_d   [NumRules];
  logic [YW-1:0]             y_q   [NumRules];
  logic [YW-1:0]             e_x, c_x;
  logic                      wv_q;

  logic signed [ProdW-1:0]   p_q  [NumRules];
  logic [MuW-1:0]            pw_q [NumRules];
  logic                      pv_q;

  logic signed [NumW-1:0]    na_q [NumSets];
  logic [DenW-1:0]           da_q [NumSets];
  logic                      av_q;

  logic signed [NumW-1:0]    num_q;
  logic [DenW-1:0]           den_q;
  logic                      bv_q;

  logic [NumW-1:0]           anum;
  out_div_t                  od_q [OutStages+1];
  logic [OutStages:0]        ov_q;

  logic signed [SatW-1:0]    qv;
  logic [OutW-1:0]           sat;
  logic                      out_vld_q;
  logic [OutW-1:0]           ctl_q;
  logic                      nrf_q;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = ctl_q;
  assign m_axis_tuser_o  = nrf_q;

  assign in_e = s_axis_tdata_i[SampleW-1:0];
  assign in_c = s_axis_tdata_i[2*SampleW-1:SampleW];
  assign s_e  = 1'b0;
  assign s_c  = s_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumPeaks; k++) begin
        peak_q[k] <= PeakReset[k];
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ERR_LOW:  peak_q[CFG_ERR_LOW]  <= cfg_data_i;
        CFG_ERR_MID:  peak_q[CFG_ERR_MID]  <= cfg_data_i;
        CFG_ERR_HIGH: peak_q[CFG_ERR_HIGH] <= cfg_data_i;
        CFG_CHG_LOW:  peak_q[CFG_CHG_LOW]  <= cfg_data_i;
        CFG_CHG_MID:  peak_q[CFG_CHG_MID]  <= cfg_data_i;
        CFG_CHG_HIGH: peak_q[CFG_CHG_HIGH] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic mu_div_t classify(input logic signed [SampleW-1:0] t,
                                       input logic signed [SampleW-1:0] l,
                                       input logic signed [SampleW-1:0] m,
                                       input logic signed [SampleW-1:0] r);
    logic signed [DiffW-1:0] tx, lx, mx, rx;
    mu_div_t                 o;
    tx     = {t[SampleW-1], t};
    lx     = {l[SampleW-1], l};
    mx     = {m[SampleW-1], m};
    rx     = {r[SampleW-1], r};
    o.kind = MU_ZERO;
    o.rem  = '0;
    o.den  = '0;
    o.q    = '0;
    if (t == m) begin
      o.kind = MU_ONE;
    end else if (t > l && t < m) begin
      o.kind = MU_DIV;
      o.rem  = RemW'($unsigned(tx - lx));
      o.den  = RemW'($unsigned(mx - lx));
    end else if (t > l && t > m && t < r) begin
      o.kind = MU_DIV;
      o.rem  = RemW'($unsigned(rx - tx));
      o.den  = RemW'($unsigned(rx - mx));
    end
    return o;
  endfunction

  // fuzzify
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q[0] <= 1'b0;
    end else if (en) begin
      mv_q[0] <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q[0][0] <= classify(in_e, peak_q[CFG_ERR_LOW], peak_q[CFG_ERR_LOW],
                             peak_q[CFG_ERR_MID]);
      md_q[0][1] <= classify(in_e, peak_q[CFG_ERR_LOW], peak_q[CFG_ERR_MID],
                             peak_q[CFG_ERR_HIGH]);
      md_q[0][2] <= classify(in_e, peak_q[CFG_ERR_MID], peak_q[CFG_ERR_HIGH],
                             peak_q[CFG_ERR_HIGH]);
      md_q[0][3] <= classify(in_c, peak_q[CFG_CHG_LOW], peak_q[CFG_CHG_LOW],
                             peak_q[CFG_CHG_MID]);
      md_q[0][4] <= classify(in_c, peak_q[CFG_CHG_LOW], peak_q[CFG_CHG_MID],
                             peak_q[CFG_CHG_HIGH]);
      md_q[0][5] <= classify(in_c, peak_q[CFG_CHG_MID], peak_q[CFG_CHG_HIGH],
                             peak_q[CFG_CHG_HIGH]);
      me_q[0]    <= in_e;
      mc_q[0]    <= in_c;
    end
  end

  // membership dividers
  for (genvar s = 1; s <= MuStages; s++) begin : g_mu_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[s] <= 1'b0;
      end else if (en) begin
        mv_q[s] <= mv_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < NumMu; k++) begin
          md_q[s][k] <= mu_adv(md_q[s-1][k]);
        end
        me_q[s] <= me_q[s-1];
        mc_q[s] <= mc_q[s-1];
      end
    end
  end

  // rule weights and rule outputs
  always_comb begin
    for (int k = 0; k < NumMu; k++) begin
      case (md_q[MuStages][k].kind)
        MU_ONE:  mu[k] = MuW'(1) << MuFrac;
        MU_DIV:  mu[k] = {1'b0, md_q[MuStages][k].q};
        default: mu[k] = '0;
      endcase
    end
    e_x = YW'(me_q[MuStages]);
    c_x = YW'(mc_q[MuStages]);
    for (int i = 0; i < NumSets; i++) begin
      for (int j = 0; j < NumSets; j++) begin
        wprod[i*NumSets+j] = mu[i] * mu[NumSets+j];
        w_d[i*NumSets+j]   = wprod[i*NumSets+j][MuFrac+MuW-1:MuFrac];
        y_d[i*NumSets+j]   = YW'(YW'(i + 1) * e_x) + YW'(YW'(j + 1) * c_x);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= 1'b0;
      pv_q <= 1'b0;
      av_q <= 1'b0;
      bv_q <= 1'b0;
    end else if (en) begin
      wv_q <= mv_q[MuStages];
      pv_q <= wv_q;
      av_q <= pv_q;
      bv_q <= av_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < NumRules; r++) begin
        w_q[r]  <= w_d[r];
        y_q[r]  <= y_d[r];
        p_q[r]  <= $signed({1'b0, w_q[r]}) * $signed(y_q[r]);
        pw_q[r] <= w_q[r];
      end
      for (int g = 0; g < NumSets; g++) begin
        na_q[g] <= NumW'(p_q[g*NumSets]) + NumW'(p_q[g*NumSets+1])
                 + NumW'(p_q[g*NumSets+2]);
        da_q[g] <= DenW'(pw_q[g*NumSets]) + DenW'(pw_q[g*NumSets+1])
                 + DenW'(pw_q[g*NumSets+2]);
      end
      num_q <= na_q[0] + na_q[1] + na_q[2];
      den_q <= da_q[0] + da_q[1] + da_q[2];
    end
  end

  // output divider
  assign anum = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q[0] <= 1'b0;
    end else if (en) begin
      ov_q[0] <= bv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      od_q[0].fired <= (den_q != '0);
      od_q[0].neg   <= num_q[NumW-1] ^ s_c;
      od_q[0].rem   <= RemW'(anum >> OutBits);
      od_q[0].den   <= RemW'(den_q);
      od_q[0].lo    <= anum[OutBits-1:0];
      od_q[0].q     <= '0;
    end
  end

  for (genvar s = 1; s <= OutStages; s++) begin : g_out_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ov_q[s] <= 1'b0;
      end else if (en) begin
        ov_q[s] <= ov_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        od_q[s] <= out_adv(od_q[s-1]);
      end
    end
  end

  // sign, saturate, register out
  always_comb begin
    qv = od_q[OutStages].neg ? -$signed(SatW'(od_q[OutStages].q))
                             :  $signed(SatW'(od_q[OutStages].q));
    if (qv > SatMax) begin
      sat = OutW'(SatMax);
    end else if (qv < SatMin) begin
      sat = OutW'(SatMin);
    end else begin
      sat = OutW'(qv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= ov_q[OutStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q <= od_q[OutStages].fired ? sat : '0;
      nrf_q <= !od_q[OutStages].fired;
    end
  end

endmodule

// ===== rtl/sfc_checker.sv =====
// Port-level checker of the fuzzy controller and its bind
`include "sugeno_fuzzy_controller_defines.svh"

module sfc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tready_o,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [sfc_pkg::OutW-1:0]    m_axis_tdata_o,
  input logic                        m_axis_tuser_o
);

  `SFC_ASSERT_NOW(a_no_rule_zero, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == '0, "output nonzero with no rule fired")

  `SFC_ASSERT_NOW(a_ready_follows_out, 1'b1, s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i), "input ready does not track output stall")

  `SFC_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled output beat changed")

endmodule

bind sugeno_fuzzy_controller sfc_checker u_sfc_checker (.*);

// ===== test/sugeno_fuzzy_controller_test.sv =====
// Testbench for the fuzzy controller: directed table, random beats, predictor check
`timescale 1ns / 1ps

module sugeno_fuzzy_controller_test;
  import sfc_pkg::*;

  localparam int NumRandom = 1925;
  localparam int DrainCycles = 40;

  typedef struct {
    logic signed [15:0] err;
    logic signed [15:0] chg;
    bit                 typed;
    logic [23:0]        want_out;
    logic               want_none;
  } stim_row_t;

  typedef struct {
    logic [23:0] out;
    logic        none;
  } control_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [SampleW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [InW-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OutW-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  sugeno_fuzzy_controller dut (.*);

  always #2 clk_i = ~clk_i;

  logic signed [15:0] peaks [NumPeaks];
  control_t pending_q [$];
  int mismatches = 0;
  int checked = 0;
  int quiet_hits = 0;
  int hold_off = 0;
  bit stim_done = 1'b0;
  stim_row_t table_rows [$];

  function automatic longint membership(longint t, longint l, longint m, longint r);
    if (t == m) return 65536;
    if (t <= l) return 0;
    if (t < m) return ((t - l) * 65536) / (m - l);
    if (t < r) return ((r - t) * 65536) / (r - m);
    return 0;
  endfunction

  function automatic control_t predict_control(logic signed [15:0] e,
                                               logic signed [15:0] c);
    longint mue [3];
    longint muc [3];
    longint num, den, w, y, res;
    control_t o;
    mue[0] = membership(e, peaks[0], peaks[0], peaks[1]);
    mue[1] = membership(e, peaks[0], peaks[1], peaks[2]);
    mue[2] = membership(e, peaks[1], peaks[2], peaks[2]);
    muc[0] = membership(c, peaks[3], peaks[3], peaks[4]);
    muc[1] = membership(c, peaks[3], peaks[4], peaks[5]);
    muc[2] = membership(c, peaks[4], peaks[5], peaks[5]);
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        w = (mue[i] * muc[j]) / 65536;
        y = (i + 1) * longint'(e) + (j + 1) * longint'(c);
        num += w * y;
        den += w;
      end
    end
    if (den > 0) begin
      res = num / den;
      if (res > 8388607) res = 8388607;
      if (res < -8388608) res = -8388608;
      o.out = res[23:0];
      o.none = 1'b0;
    end else begin
      o.out = '0;
      o.none = 1'b1;
    end
    return o;
  endfunction

  task automatic write_peak(cfg_idx_e idx, logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx <= CFG_CHG_HIGH) peaks[idx] = value;
  endtask

  task automatic write_bad_index();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgIdxW'(6 + $urandom_range(0, 1));
    cfg_data_i <= 16'($urandom);
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [15:0] e, logic signed [15:0] c,
                             bit typed, logic [23:0] want_out, logic want_none,
                             bit gaps);
    control_t exp_r;
    int gap;
    gap = gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    exp_r = predict_control(e, c);
    if (typed) begin
      exp_r.out = want_out;
      exp_r.none = want_none;
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {c, e};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_q.push_back(exp_r);
  endtask

  task automatic drain_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] near_value(logic signed [15:0] lo,
                                                    logic signed [15:0] hi);
    int a, b;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    a -= 300;
    b += 300;
    if (a < -32768) a = -32768;
    if (b > 32767) b = 32767;
    return 16'(a + int'($urandom_range(0, b - a)));
  endfunction

  task automatic random_peaks(bit ordered);
    logic signed [15:0] v [6];
    logic signed [15:0] t;
    for (int k = 0; k < 6; k++) v[k] = ordered ? 16'($urandom_range(0, 4000) - 2000)
                                               : edge_value();
    if (ordered) begin
      for (int g = 0; g < 6; g += 3)
        for (int a = g; a < g + 3; a++)
          for (int b = a + 1; b < g + 3; b++)
            if (v[b] < v[a]) begin
              t = v[a]; v[a] = v[b]; v[b] = t;
            end
    end
    for (int k = 0; k < 6; k++) write_peak(cfg_idx_e'(k), v[k]);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    control_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat out=%h none=%b",
                                       m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        exp_r = pending_q.pop_front();
        checked++;
        if (m_axis_tuser_o) quiet_hits++;
        if (m_axis_tdata_o !== exp_r.out || m_axis_tuser_o !== exp_r.none) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected out=%h none=%b, got out=%h none=%b",
                     exp_r.out, exp_r.none, m_axis_tdata_o, m_axis_tuser_o);
        end
      end
    end
  end

  int ready_wait = 0;
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready_i <= 1'b0;
    end else if (ready_wait > 0) begin
      ready_wait <= ready_wait - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!m_axis_tready_i || m_axis_tvalid_o) begin
      m_axis_tready_i <= 1'b1;
      if (m_axis_tvalid_o && m_axis_tready_i && !stim_done && ($urandom_range(0, 3) != 0))
        ready_wait <= $urandom_range(0, 7);
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL sugeno_fuzzy_controller");
    $finish;
  end

  initial begin
    stim_row_t row;
    logic signed [15:0] e, c;
    for (int k = 0; k < NumPeaks; k++) peaks[k] = PeakReset[k];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    table_rows = '{
      '{16'sd2560, 16'sd512, 1'b1, 24'(2 * 2560 + 2 * 512), 1'b0},
      '{16'sd1280, 16'sd256, 1'b1, 24'(1280 + 256), 1'b0},
      '{16'sd3840, 16'sd768, 1'b1, 24'(3 * 3840 + 3 * 768), 1'b0},
      '{16'sd1280, 16'sd768, 1'b1, 24'(1280 + 3 * 768), 1'b0},
      '{16'sh8000, 16'sh8000, 1'b1, 24'd0, 1'b1},
      '{16'sh7fff, 16'sh7fff, 1'b1, 24'd0, 1'b1},
      '{16'sh7fff, 16'sh8000, 1'b1, 24'd0, 1'b1},
      '{16'sd0, 16'sd0, 1'b1, 24'd0, 1'b1},
      '{16'sd1279, 16'sd512, 1'b1, 24'd0, 1'b1},
      '{16'sd3841, 16'sd512, 1'b1, 24'd0, 1'b1},
      '{16'sd1920, 16'sd384, 1'b0, 24'd0, 1'b0},
      '{16'sd3200, 16'sd640, 1'b0, 24'd0, 1'b0},
      '{16'sd1281, 16'sd767, 1'b0, 24'd0, 1'b0},
      '{16'sd3839, 16'sd257, 1'b0, 24'd0, 1'b0},
      '{16'sd2559, 16'sd513, 1'b0, 24'd0, 1'b0},
      '{16'sh5555, 16'shaaaa, 1'b0, 24'd0, 1'b0}
    };
    foreach (table_rows[k]) begin
      row = table_rows[k];
      send_sample(row.err, row.chg, row.typed, row.want_out, row.want_none, 1'b1);
    end
    drain_idle();

    // out-of-order and coincident peaks, extreme ends of the range
    write_peak(CFG_ERR_LOW, 16'h7fff);
    write_peak(CFG_ERR_MID, 16'h0000);
    write_peak(CFG_ERR_HIGH, 16'h8000);
    write_peak(CFG_CHG_LOW, 16'h8000);
    write_peak(CFG_CHG_MID, 16'h8000);
    write_peak(CFG_CHG_HIGH, 16'h7fff);
    write_bad_index();
    cfg_we_i <= 1'b0;
    send_sample(16'sh7fff, 16'sh8000, 1'b0, '0, 1'b0, 1'b1);
    send_sample(16'sh0000, 16'sh7fff, 1'b0, '0, 1'b0, 1'b1);
    send_sample(16'sh8000, 16'sh0000, 1'b0, '0, 1'b0, 1'b1);
    send_sample(16'sh4000, 16'shc000, 1'b0, '0, 1'b0, 1'b1);
    drain_idle();

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 150 == 0) begin
        drain_idle();
        if ($urandom_range(0, 3) == 0) write_bad_index();
        random_peaks($urandom_range(0, 4) != 0);
      end
      if (n == 600) hold_off = 200;
      if ($urandom_range(0, 9) == 0) begin
        e = 16'($urandom);
        c = 16'($urandom);
      end else begin
        e = near_value(peaks[0], peaks[2]);
        c = near_value(peaks[3], peaks[5]);
      end
      send_sample(e, c, 1'b0, '0, 1'b0, (n % 300) > 40);
    end
    stim_done = 1'b1;
    drain_idle();

    $display("Checked %0d beats, %0d with no rule firing, over %0d peak settings.",
             checked, quiet_hits, NumRandom / 150 + 3);
    if (mismatches == 0) begin
      $display("PASS sugeno_fuzzy_controller");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL sugeno_fuzzy_controller");
    end
    $finish;
  end

endmodule
